>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file sd3b_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_CLK_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/sd3b_pkg.sv
// ----------------------------------------------------------------------------
// sd3b_pkg
// Shared constants and types of the stereo triangulation / 3D box block.
// ----------------------------------------------------------------------------
package sd3b_pkg;

   // parameter defaults
   localparam int COORD_FRAC_BITS_DEF = 4;
   localparam int OUT_WIDTH_DEF       = 32;

   // fixed field widths
   localparam int COORD_W    = 16;
   localparam int FOCAL_W    = 14;
   localparam int BASE_W     = 16;
   localparam int IMG_W      = 13;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   // register reset values
   localparam logic [FOCAL_W-1:0] FOCAL_RST  = FOCAL_W'(1000);
   localparam logic [BASE_W-1:0]  BASE_RST   = BASE_W'(100);
   localparam logic [IMG_W-1:0]   WIDTH_RST  = IMG_W'(640);
   localparam logic [IMG_W-1:0]   HEIGHT_RST = IMG_W'(480);

   // register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_FOCAL  = 3'd0,
      REG_BASE   = 3'd1,
      REG_WIDTH  = 3'd2,
      REG_HEIGHT = 3'd3
   } csr_reg_type;

   // arithmetic lanes
   localparam int NUM_LANES = 3;
   localparam int LANE_X    = 0;
   localparam int LANE_Y    = 1;
   localparam int LANE_Z    = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_PREP,
      ST_DIV,
      ST_SAT,
      ST_BOX,
      ST_DONE
   } state_type;

endpackage

>>> rtl/stereo_disparity_to_3d_bbox.sv
// ----------------------------------------------------------------------------
// stereo_disparity_to_3d_bbox
// Stereo triangulation of matched point pairs with a running 3D bounding box.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one matched pair per item (left_x, left_y, right_x, right_y
//    in tdata, last pair of a set on tlast). rsp_* returns one result item per
//    pair: the 3D point, and on the last pair (rsp_tlast) the box center and
//    size. rsp_tuser flags a zero-disparity pair (point forced to zero).
//  - csr_* writes focal length, baseline, image width and height; write only
//    while the block is idle. Unknown indexes are ignored.
//  - Sequence: one item at a time. After acceptance a bit-serial multiply runs
//    over the baseline bits, then a radix-2 restoring divide, then saturate,
//    box update and output load. Zero-disparity pairs skip the arithmetic.
//  - A finished item sits in the output register; if rsp_tready is low the
//    block holds it, and the next result waits in the done state until it is free.
//  - Synchronous reset restores register defaults, empties the box and drops
//    rsp_tvalid.
// ----------------------------------------------------------------------------
module stereo_disparity_to_3d_bbox #(
   parameter int COORD_FRAC_BITS = sd3b_pkg::COORD_FRAC_BITS_DEF,
   parameter int OUT_WIDTH       = sd3b_pkg::OUT_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration write port
   input  logic                                   csr_we,
   input  logic [sd3b_pkg::CSR_ADDR_W-1:0]        csr_index,
   input  logic [sd3b_pkg::CSR_DATA_W-1:0]        csr_wdata,
   // pair input
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // left_x, left_y, right_x, right_y (16 bits each, from bit 0 up)
   input  logic [4*sd3b_pkg::COORD_W-1:0]         req_tdata,
   input  logic                                   req_tlast,
   // result output
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // point_x, point_y, point_z, center_x, center_y, center_z (OUT_WIDTH each),
   // size_x, size_y, size_z (OUT_WIDTH-1 each), zero padded to bytes
   output logic [((9*OUT_WIDTH-3+7)/8)*8-1:0]     rsp_tdata,
   // zero_disparity
   output logic                                   rsp_tuser,
   // set_done
   output logic                                   rsp_tlast
);

   localparam int CFB   = COORD_FRAC_BITS;
   localparam int OW    = OUT_WIDTH;
   localparam int CW    = sd3b_pkg::COORD_W;
   localparam int BW    = sd3b_pkg::BASE_W;
   localparam int NL    = sd3b_pkg::NUM_LANES;
   localparam int RSP_W = ((9*OW-3+7)/8)*8;
   // signed width of the doubled principal-point offsets
   localparam int DXS   = ((sd3b_pkg::IMG_W+CFB > CW+1) ? sd3b_pkg::IMG_W+CFB : CW+1) + 1;
   localparam int DXW   = DXS - 1;
   localparam int OPW   = (DXW > sd3b_pkg::FOCAL_W) ? DXW : sd3b_pkg::FOCAL_W;
   localparam int PW    = OPW + BW;           // product width
   localparam int NW    = PW + 2*CFB;         // numerator magnitude width
   localparam int MW    = NW + 2;             // rounded dividend width
   localparam int VW    = CW + 2;             // divisor width (up to 4*|d|)
   localparam int QX    = ((MW > OW) ? MW : OW) + 1;
   localparam int CNT_W = $clog2(MW);

   localparam logic [QX-1:0]        OMAX_Q = QX'((QX'(1) << (OW-1)) - QX'(1));
   localparam logic signed [OW-1:0] OMAX_S = {1'b0, {(OW-1){1'b1}}};
   localparam logic signed [OW-1:0] OMIN_S = {1'b1, {(OW-1){1'b0}}};

   // configuration registers
   logic [sd3b_pkg::FOCAL_W-1:0] focal_ff;
   logic [BW-1:0]                base_ff;
   logic [sd3b_pkg::IMG_W-1:0]   width_ff;
   logic [sd3b_pkg::IMG_W-1:0]   height_ff;

   // control
   sd3b_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                req_accept;
   logic                rsp_load;
   logic                rsp_valid_ff;

   // input unpacking and pre-processing
   logic [CW-1:0]   xl, yl, xr, yr;
   logic [CW:0]     d_full, d_negated;
   logic            dneg;
   logic [CW-1:0]   dmag;
   logic            zero_in;
   logic [DXS-1:0]  dx2, dy2, dx2_neg, dy2_neg;
   logic [DXW-1:0]  xmag, ymag;

   // per-lane datapath: X, Y, Z
   logic [OPW-1:0]        op_ff    [NL];
   logic [PW-1:0]         acc_ff   [NL];
   logic [PW-1:0]         acc_in   [NL];
   logic [MW-1:0]         num_ff   [NL];
   logic [MW-1:0]         num_in   [NL];
   logic [MW-1:0]         num_prep [NL];
   logic [VW-1:0]         rem_ff   [NL];
   logic [VW-1:0]         rem_in   [NL];
   logic [VW-1:0]         div_ff   [NL];
   logic [VW:0]           trial    [NL];
   logic                  ge       [NL];
   logic                  neg_ff   [NL];
   logic [QX-1:0]         qx       [NL];
   logic [QX-1:0]         qn       [NL];
   logic signed [OW-1:0]  pnt_ff   [NL];
   logic signed [OW-1:0]  pnt_in   [NL];
   logic [BW-1:0]         mulb_ff;
   logic                  zero_ff;
   logic                  last_ff;

   // running box
   logic signed [OW-1:0]  bmin_ff  [NL];
   logic signed [OW-1:0]  bmax_ff  [NL];
   logic                  any_ff;
   logic signed [OW:0]    bsum     [NL];
   logic signed [OW:0]    bdiff    [NL];
   logic [OW-1:0]         cen      [NL];
   logic [OW-2:0]         siz      [NL];

   // output register
   logic [OW-1:0]         out_pnt_ff [NL];
   logic [OW-1:0]         out_cen_ff [NL];
   logic [OW-2:0]         out_siz_ff [NL];
   logic                  out_zero_ff;
   logic                  out_last_ff;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff  <= sd3b_pkg::FOCAL_RST;
         base_ff   <= sd3b_pkg::BASE_RST;
         width_ff  <= sd3b_pkg::WIDTH_RST;
         height_ff <= sd3b_pkg::HEIGHT_RST;
      end else if (csr_we) begin
         case (csr_index)
            sd3b_pkg::REG_FOCAL:  focal_ff  <= csr_wdata[sd3b_pkg::FOCAL_W-1:0];
            sd3b_pkg::REG_BASE:   base_ff   <= csr_wdata[BW-1:0];
            sd3b_pkg::REG_WIDTH:  width_ff  <= csr_wdata[sd3b_pkg::IMG_W-1:0];
            sd3b_pkg::REG_HEIGHT: height_ff <= csr_wdata[sd3b_pkg::IMG_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- input
   assign xl = req_tdata[CW-1:0];
   assign yl = req_tdata[2*CW-1:CW];
   assign xr = req_tdata[3*CW-1:2*CW];
   assign yr = req_tdata[4*CW-1:3*CW];

   always_comb begin
      d_full    = {1'b0, xl} - {1'b0, xr};
      d_negated = (CW+1)'(0) - d_full;
      dneg      = d_full[CW];
      dmag      = dneg ? d_negated[CW-1:0] : d_full[CW-1:0];
      zero_in   = (xl == xr);
      // offsets from the principal point, in half-LSB units
      dx2       = (DXS'(width_ff) << CFB) - DXS'({xl, 1'b0});
      dy2       = DXS'(yl) + DXS'(yr) - (DXS'(height_ff) << CFB);
      dx2_neg   = DXS'(0) - dx2;
      dy2_neg   = DXS'(0) - dy2;
      xmag      = dx2[DXS-1] ? dx2_neg[DXW-1:0] : dx2[DXW-1:0];
      ymag      = dy2[DXS-1] ? dy2_neg[DXW-1:0] : dy2[DXW-1:0];
   end

   // ---------------------------------------------------------------- FSM
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sd3b_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      req_tready = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         sd3b_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cnt_in   = CNT_W'(BW-1);
               state_in = zero_in ? sd3b_pkg::ST_DONE : sd3b_pkg::ST_MUL;
            end
         end
         sd3b_pkg::ST_MUL: begin
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) state_in = sd3b_pkg::ST_PREP;
         end
         sd3b_pkg::ST_PREP: begin
            cnt_in   = CNT_W'(MW-1);
            state_in = sd3b_pkg::ST_DIV;
         end
         sd3b_pkg::ST_DIV: begin
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) state_in = sd3b_pkg::ST_SAT;
         end
         sd3b_pkg::ST_SAT: state_in = sd3b_pkg::ST_BOX;
         sd3b_pkg::ST_BOX: state_in = sd3b_pkg::ST_DONE;
         sd3b_pkg::ST_DONE: begin
            // wait for a free output register
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = sd3b_pkg::ST_IDLE;
            end
         end
         default: state_in = sd3b_pkg::ST_IDLE;
      endcase
   end

   assign req_accept = req_tvalid && req_tready;

   // ---------------------------------------------------------------- lanes
   always_comb begin
      for (int l = 0; l < NL; l++) begin
         // MSB-first shift-add over the baseline bits
         acc_in[l] = {acc_ff[l][PW-2:0], 1'b0} + (mulb_ff[BW-1] ? PW'(op_ff[l]) : PW'(0));
         // dividend 2n + D, divisor 2D: rounds half away from zero
         if (l == sd3b_pkg::LANE_Z) begin
            num_prep[l] = (MW'(acc_ff[l]) << (2*CFB+1)) + MW'(div_ff[l][VW-1:1]);
         end else begin
            num_prep[l] = (MW'(acc_ff[l]) << (CFB+1)) + MW'(div_ff[l][VW-1:1]);
         end
         // one restoring division step, quotient bits shift in from the bottom
         trial[l]  = {rem_ff[l], num_ff[l][MW-1]};
         ge[l]     = (trial[l] >= {1'b0, div_ff[l]});
         rem_in[l] = ge[l] ? VW'(trial[l] - {1'b0, div_ff[l]}) : trial[l][VW-1:0];
         num_in[l] = {num_ff[l][MW-2:0], ge[l]};
         // sign and saturate
         qx[l] = QX'(num_ff[l]);
         qn[l] = QX'(0) - qx[l];
         if (neg_ff[l]) begin
            pnt_in[l] = (qx[l] > OMAX_Q + QX'(1)) ? OMIN_S : signed'(qn[l][OW-1:0]);
         end else begin
            pnt_in[l] = (qx[l] > OMAX_Q) ? OMAX_S : signed'(qx[l][OW-1:0]);
         end
         // box center (floor of the mean) and extent
         bsum[l]  = {bmin_ff[l][OW-1], bmin_ff[l]} + {bmax_ff[l][OW-1], bmax_ff[l]};
         bdiff[l] = {bmax_ff[l][OW-1], bmax_ff[l]} - {bmin_ff[l][OW-1], bmin_ff[l]};
         cen[l]   = bsum[l][OW:1];
         siz[l]   = (bdiff[l][OW] || bdiff[l][OW-1]) ? {(OW-1){1'b1}} : bdiff[l][OW-2:0];
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         sd3b_pkg::ST_IDLE: begin
            if (req_accept) begin
               op_ff[sd3b_pkg::LANE_X]  <= OPW'(xmag);
               op_ff[sd3b_pkg::LANE_Y]  <= OPW'(ymag);
               op_ff[sd3b_pkg::LANE_Z]  <= OPW'(focal_ff);
               // result sign: numerator is -offset*B (or -f*B), divisor d
               neg_ff[sd3b_pkg::LANE_X] <= ~dx2[DXS-1] ^ dneg;
               neg_ff[sd3b_pkg::LANE_Y] <= ~dy2[DXS-1] ^ dneg;
               neg_ff[sd3b_pkg::LANE_Z] <= ~dneg;
               div_ff[sd3b_pkg::LANE_X] <= {dmag, 2'b00};
               div_ff[sd3b_pkg::LANE_Y] <= {dmag, 2'b00};
               div_ff[sd3b_pkg::LANE_Z] <= {1'b0, dmag, 1'b0};
               mulb_ff <= base_ff;
               zero_ff <= zero_in;
               last_ff <= req_tlast;
               for (int l = 0; l < NL; l++) begin
                  acc_ff[l] <= '0;
                  pnt_ff[l] <= '0;
               end
            end
         end
         sd3b_pkg::ST_MUL: begin
            mulb_ff <= {mulb_ff[BW-2:0], 1'b0};
            for (int l = 0; l < NL; l++) acc_ff[l] <= acc_in[l];
         end
         sd3b_pkg::ST_PREP: begin
            for (int l = 0; l < NL; l++) begin
               num_ff[l] <= num_prep[l];
               rem_ff[l] <= '0;
            end
         end
         sd3b_pkg::ST_DIV: begin
            for (int l = 0; l < NL; l++) begin
               num_ff[l] <= num_in[l];
               rem_ff[l] <= rem_in[l];
            end
         end
         sd3b_pkg::ST_SAT: begin
            for (int l = 0; l < NL; l++) pnt_ff[l] <= pnt_in[l];
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- box
   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff <= 1'b0;
         for (int l = 0; l < NL; l++) begin
            bmin_ff[l] <= OMAX_S;
            bmax_ff[l] <= OMIN_S;
         end
      end else if (state_ff == sd3b_pkg::ST_BOX) begin
         // only valid points reach this state
         any_ff <= 1'b1;
         for (int l = 0; l < NL; l++) begin
            if (pnt_ff[l] < bmin_ff[l]) bmin_ff[l] <= pnt_ff[l];
            if (pnt_ff[l] > bmax_ff[l]) bmax_ff[l] <= pnt_ff[l];
         end
      end else if (rsp_load && last_ff) begin
         any_ff <= 1'b0;
         for (int l = 0; l < NL; l++) begin
            bmin_ff[l] <= OMAX_S;
            bmax_ff[l] <= OMIN_S;
         end
      end
   end

   // ---------------------------------------------------------------- output
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         out_zero_ff <= zero_ff;
         out_last_ff <= last_ff;
         for (int l = 0; l < NL; l++) begin
            out_pnt_ff[l] <= pnt_ff[l];
            out_cen_ff[l] <= (last_ff && any_ff) ? cen[l] : '0;
            out_siz_ff[l] <= (last_ff && any_ff) ? siz[l] : '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_zero_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = RSP_W'({out_siz_ff[sd3b_pkg::LANE_Z], out_siz_ff[sd3b_pkg::LANE_Y],
                               out_siz_ff[sd3b_pkg::LANE_X], out_cen_ff[sd3b_pkg::LANE_Z],
                               out_cen_ff[sd3b_pkg::LANE_Y], out_cen_ff[sd3b_pkg::LANE_X],
                               out_pnt_ff[sd3b_pkg::LANE_Z], out_pnt_ff[sd3b_pkg::LANE_Y],
                               out_pnt_ff[sd3b_pkg::LANE_X]});

endmodule

>>> rtl/sd3b_checker.sv
// ----------------------------------------------------------------------------
// sd3b_checker
// Port-level assertions for the stereo triangulation block, bound to its top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sd3b_checker #(
   parameter int OUT_WIDTH = sd3b_pkg::OUT_WIDTH_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               req_tlast,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [((9*OUT_WIDTH-3+7)/8)*8-1:0] rsp_tdata,
   input logic                               rsp_tuser,
   input logic                               rsp_tlast
);

   localparam int PNT_HI = 3*OUT_WIDTH - 1;
   localparam int BOX_LO = 3*OUT_WIDTH;
   localparam int BOX_HI = 9*OUT_WIDTH - 4;

   logic req_accept;
   assign req_accept = req_tvalid && req_tready && (req_tlast || !req_tlast);

   `ASSERT_CLK_NORST(a_reset_drops_valid, clock, reset |=> !rsp_tvalid, "rsp_tvalid after reset")

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   `ASSERT_CLK(a_one_item_at_a_time, clock, reset, req_accept |=> !req_tready, "item taken while busy")

   `ASSERT_CLK(a_zero_disp_point, clock, reset, rsp_tvalid && rsp_tuser |-> (rsp_tdata[PNT_HI:0] == '0), "zero disparity point not zero")

   `ASSERT_CLK(a_box_only_on_last, clock, reset, rsp_tvalid && !rsp_tlast |-> (rsp_tdata[BOX_HI:BOX_LO] == '0), "box fields set on non-last item")

endmodule

bind stereo_disparity_to_3d_bbox sd3b_checker #(.OUT_WIDTH(OUT_WIDTH)) u_sd3b_checker (.*);
